// ===== hdl/pbd_pkg.sv =====
// Package for the polyphase box downsampler.
// Holds the widths, register indexes and bus types used by the interfaces, the top level and the divider.
// Depends on nothing.
package pbd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W = 13;
  localparam int CNT_W = 12;
  localparam int COORD_W = 11;
  localparam int REG_IDX_W = 8;
  localparam int MAX_WIDTH = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int ACC_DEPTH = MAX_WIDTH / 2;
  localparam int ADDR_W = $clog2(ACC_DEPTH);
  localparam int PART_W = 32;
  localparam int HSUM_W = 28;
  localparam int ACC_W = 40;
  localparam int DIV_W = 24;
  localparam int NUM_W = ACC_W + 1;
  localparam int QUO_W = SAMPLE_W + 1;
  localparam int QCNT_W = $clog2(QUO_W);

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(2);

  localparam logic [REG_IDX_W-1:0] REG_SOURCE_WIDTH = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_SOURCE_HEIGHT = REG_IDX_W'(1);

  typedef struct packed {
    logic start;
    logic [NUM_W-1:0] numer;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hdl/pbd_ifs.sv =====
// Channel interfaces of the polyphase box downsampler.
// Sample input, result output and register write channels.
// Depends on pbd_pkg for the field widths.
interface pbd_sample_if;
  logic valid;
  logic ready;
  logic [pbd_pkg::SAMPLE_W-1:0] sample_value;
  modport source(output valid, sample_value, input ready);
  modport sink(input valid, sample_value, output ready);
endinterface

interface pbd_result_if;
  logic valid;
  logic ready;
  logic [pbd_pkg::SAMPLE_W-1:0] filtered_value;
  logic [pbd_pkg::COORD_W-1:0] out_column;
  logic [pbd_pkg::COORD_W-1:0] out_row;
  logic frame_done;
  modport source(output valid, filtered_value, out_column, out_row, frame_done, input ready);
  modport sink(input valid, filtered_value, out_column, out_row, frame_done, output ready);
endinterface

interface pbd_cfg_if;
  logic valid;
  logic ready;
  logic [pbd_pkg::REG_IDX_W-1:0] reg_index;
  logic [pbd_pkg::CFG_W-1:0] reg_data;
  modport source(output valid, reg_index, reg_data, input ready);
  modport sink(input valid, reg_index, reg_data, output ready);
endinterface

// ===== hdl/polyphase_box_downsample.sv =====
// Polyphase box downsampler, top level. Depends on pbd_pkg, pbd_ifs, pbd_ram, pbd_div.
// An item that completes no output passes through the vertical step and back to idle; one
// that completes an output also waits for the 17-step divider and then for the output
// register; a held result register adds its stall. The RAM read-modify-write sets the floor.
// Synchronous reset clears the counts, the column partial and the sizes (2 x 2).
// The accumulator RAMs are not cleared; every entry is written before it is read.
module polyphase_box_downsample (
  input  logic clk,
  input  logic rst,
  pbd_sample_if.sink   sample_in,
  pbd_result_if.source result_out,
  pbd_cfg_if.sink      cfg
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_VERT = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [pbd_pkg::CFG_W-1:0] width_reg, height_reg;
  logic [pbd_pkg::CFG_W-1:0] w, h;
  logic [pbd_pkg::CNT_W-1:0] col_cnt, row_cnt, c_eff, r_eff;
  logic [pbd_pkg::PART_W-1:0] partial, partial_next;
  logic in_acc, cfg_acc;

  assign cfg.ready = 1'b1;
  assign cfg_acc = cfg.valid;
  assign sample_in.ready = (state == S_IDLE);
  assign in_acc = sample_in.valid && (state == S_IDLE);

  assign w = (width_reg == '0) ? pbd_pkg::CFG_W'(1) :
             (width_reg > pbd_pkg::CFG_W'(pbd_pkg::MAX_WIDTH)) ?
             pbd_pkg::CFG_W'(pbd_pkg::MAX_WIDTH) : width_reg;
  assign h = (height_reg == '0) ? pbd_pkg::CFG_W'(1) :
             (height_reg > pbd_pkg::CFG_W'(pbd_pkg::MAX_HEIGHT)) ?
             pbd_pkg::CFG_W'(pbd_pkg::MAX_HEIGHT) : height_reg;
  assign c_eff = ({1'b0, col_cnt} >= w) ? '0 : col_cnt;
  assign r_eff = ({1'b0, row_cnt} >= h) ? '0 : row_cnt;

  // Horizontal stage.
  logic [pbd_pkg::SAMPLE_W-1:0] s;
  logic [pbd_pkg::COORD_W-1:0] hn, x_odd, x_h;
  logic [pbd_pkg::CNT_W-1:0] x1;
  logic [26:0] prod_hn, prod_hrem;
  logic [27:0] prod_x1;
  logic [pbd_pkg::HSUM_W-1:0] hsum_h;
  logic cd_h;

  assign s = sample_in.sample_value;
  assign hn = pbd_pkg::COORD_W'((w - pbd_pkg::CFG_W'(1)) >> 1);
  assign x_odd = pbd_pkg::COORD_W'((c_eff - pbd_pkg::CNT_W'(2)) >> 1);
  assign x1 = {1'b0, x_odd} + pbd_pkg::CNT_W'(1);
  assign prod_hn = 27'(hn * s);
  assign prod_x1 = 28'(x1 * s);
  assign prod_hrem = 27'((hn - x_odd - pbd_pkg::COORD_W'(1)) * s);

  always_comb begin
    partial_next = partial;
    hsum_h = '0;
    x_h = '0;
    cd_h = 1'b0;
    if (w == pbd_pkg::CFG_W'(1)) begin
      hsum_h = pbd_pkg::HSUM_W'(s);
      cd_h = 1'b1;
    end else if (!w[0]) begin
      if (!c_eff[0]) begin
        partial_next = pbd_pkg::PART_W'(s);
      end else begin
        hsum_h = pbd_pkg::HSUM_W'(partial + pbd_pkg::PART_W'(s));
        x_h = c_eff[pbd_pkg::CNT_W-1:1];
        cd_h = 1'b1;
      end
    end else begin
      if (c_eff == '0) begin
        partial_next = pbd_pkg::PART_W'(prod_hn);
      end else if (c_eff[0]) begin
        partial_next = partial + pbd_pkg::PART_W'(prod_hn);
      end else begin
        x_h = x_odd;
        hsum_h = pbd_pkg::HSUM_W'(partial + pbd_pkg::PART_W'(prod_x1));
        cd_h = 1'b1;
        partial_next = (x1 < {1'b0, hn}) ? pbd_pkg::PART_W'(prod_hrem) : '0;
      end
    end
  end

  // Raster position advance.
  logic [pbd_pkg::CFG_W-1:0] c_inc, r_inc;
  assign c_inc = {1'b0, c_eff} + pbd_pkg::CFG_W'(1);
  assign r_inc = {1'b0, r_eff} + pbd_pkg::CFG_W'(1);

  logic [pbd_pkg::HSUM_W-1:0] hsum_q;
  logic [pbd_pkg::COORD_W-1:0] x_q;
  logic [pbd_pkg::CNT_W-1:0] r_q;
  logic cd_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg <= pbd_pkg::SIZE_RESET;
      height_reg <= pbd_pkg::SIZE_RESET;
      col_cnt <= '0;
      row_cnt <= '0;
      partial <= '0;
    end else if (cfg_acc && (cfg.reg_index == pbd_pkg::REG_SOURCE_WIDTH ||
                             cfg.reg_index == pbd_pkg::REG_SOURCE_HEIGHT)) begin
      if (cfg.reg_index == pbd_pkg::REG_SOURCE_WIDTH) begin
        width_reg <= cfg.reg_data;
      end else begin
        height_reg <= cfg.reg_data;
      end
      col_cnt <= '0;
      row_cnt <= '0;
      partial <= '0;
    end else if (in_acc) begin
      partial <= partial_next;
      if (c_inc >= w) begin
        col_cnt <= '0;
        row_cnt <= (r_inc >= h) ? '0 : pbd_pkg::CNT_W'(r_inc);
      end else begin
        col_cnt <= pbd_pkg::CNT_W'(c_inc);
        row_cnt <= r_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      hsum_q <= hsum_h;
      x_q <= x_h;
      r_q <= r_eff;
      cd_q <= cd_h;
    end
  end

  // Vertical stage: read-modify-write of the accumulator RAMs.
  logic [pbd_pkg::ACC_W-1:0] cur_rdata, nxt_rdata, cur_wdata, nxt_wdata, total;
  logic cur_we, nxt_we, row_done;
  logic [pbd_pkg::COORD_W-1:0] vm, y_odd, y_v;
  logic [pbd_pkg::CNT_W-1:0] y1;
  logic [38:0] prod_vm, prod_vrem;
  logic [39:0] prod_y1;

  pbd_ram #(.WIDTH(pbd_pkg::ACC_W), .DEPTH(pbd_pkg::ACC_DEPTH)) u_cur_ram (
    .clk(clk), .we(cur_we), .waddr(x_q), .wdata(cur_wdata),
    .raddr(x_h), .rdata(cur_rdata)
  );

  pbd_ram #(.WIDTH(pbd_pkg::ACC_W), .DEPTH(pbd_pkg::ACC_DEPTH)) u_nxt_ram (
    .clk(clk), .we(nxt_we), .waddr(x_q), .wdata(nxt_wdata),
    .raddr(x_h), .rdata(nxt_rdata)
  );

  assign vm = pbd_pkg::COORD_W'((h - pbd_pkg::CFG_W'(1)) >> 1);
  assign y_odd = pbd_pkg::COORD_W'((r_q - pbd_pkg::CNT_W'(2)) >> 1);
  assign y1 = {1'b0, y_odd} + pbd_pkg::CNT_W'(1);
  assign prod_vm = 39'(vm * hsum_q);
  assign prod_y1 = 40'(y1 * hsum_q);
  assign prod_vrem = 39'((vm - y_odd - pbd_pkg::COORD_W'(1)) * hsum_q);

  always_comb begin
    cur_we = 1'b0;
    nxt_we = 1'b0;
    cur_wdata = '0;
    nxt_wdata = '0;
    total = '0;
    y_v = '0;
    row_done = 1'b0;
    if (state == S_VERT && cd_q) begin
      if (h == pbd_pkg::CFG_W'(1)) begin
        total = pbd_pkg::ACC_W'(hsum_q);
        row_done = 1'b1;
      end else if (!h[0]) begin
        if (!r_q[0]) begin
          cur_we = 1'b1;
          cur_wdata = pbd_pkg::ACC_W'(hsum_q);
        end else begin
          total = cur_rdata + pbd_pkg::ACC_W'(hsum_q);
          y_v = r_q[pbd_pkg::CNT_W-1:1];
          row_done = 1'b1;
        end
      end else begin
        if (r_q == '0) begin
          cur_we = 1'b1;
          cur_wdata = pbd_pkg::ACC_W'(prod_vm);
        end else if (r_q == pbd_pkg::CNT_W'(1)) begin
          cur_we = 1'b1;
          cur_wdata = cur_rdata + pbd_pkg::ACC_W'(prod_vm);
        end else if (r_q[0]) begin
          cur_we = 1'b1;
          cur_wdata = nxt_rdata + pbd_pkg::ACC_W'(prod_vm);
        end else begin
          y_v = y_odd;
          total = cur_rdata + prod_y1;
          row_done = 1'b1;
          nxt_we = 1'b1;
          nxt_wdata = (y1 < {1'b0, vm}) ? pbd_pkg::ACC_W'(prod_vrem) : '0;
        end
      end
    end
  end

  // Normalization.
  logic [pbd_pkg::CFG_W-1:0] tw, th;
  logic [pbd_pkg::CNT_W-1:0] ow, oh;
  logic [pbd_pkg::DIV_W-1:0] d_q;
  logic [pbd_pkg::COORD_W-1:0] y_q;
  logic frame_q;
  pbd_pkg::div_req_t div_req;
  pbd_pkg::div_rsp_t div_rsp;

  assign tw = (w == pbd_pkg::CFG_W'(1)) ? pbd_pkg::CFG_W'(1) : (w[0] ? w : pbd_pkg::CFG_W'(2));
  assign th = (h == pbd_pkg::CFG_W'(1)) ? pbd_pkg::CFG_W'(1) : (h[0] ? h : pbd_pkg::CFG_W'(2));
  assign ow = (w[pbd_pkg::CFG_W-1:1] == '0) ? pbd_pkg::CNT_W'(1) : w[pbd_pkg::CFG_W-1:1];
  assign oh = (h[pbd_pkg::CFG_W-1:1] == '0) ? pbd_pkg::CNT_W'(1) : h[pbd_pkg::CFG_W-1:1];

  always_ff @(posedge clk) begin
    d_q <= pbd_pkg::DIV_W'(tw * th);
    if (row_done) begin
      y_q <= y_v;
      frame_q <= ({1'b0, x_q} + pbd_pkg::CNT_W'(1) == ow) &&
                 ({1'b0, y_v} + pbd_pkg::CNT_W'(1) == oh);
    end
  end

  assign div_req.start = row_done;
  assign div_req.numer = {1'b0, total} + pbd_pkg::NUM_W'(d_q >> 1);
  assign div_req.divisor = d_q;

  pbd_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  logic [pbd_pkg::SAMPLE_W-1:0] quo_q;
  always_ff @(posedge clk) begin
    if (div_rsp.done) begin
      quo_q <= div_rsp.quotient[pbd_pkg::SAMPLE_W-1:0];
    end
  end

  // Control and output register.
  logic out_valid, out_free;
  assign out_free = !out_valid || result_out.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_acc) state_next = S_VERT;
      S_VERT: state_next = row_done ? S_DIV : S_IDLE;
      S_DIV:  if (div_rsp.done) state_next = S_OUT;
      S_OUT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      result_out.filtered_value <= quo_q;
      result_out.out_column <= x_q;
      result_out.out_row <= y_q;
      result_out.frame_done <= frame_q;
    end
  end

  assign result_out.valid = out_valid;

`ifndef SYNTHESIS
  a_ram_write_in_vert: assert property (@(posedge clk) disable iff (rst)
    (cur_we || nxt_we) |-> state == S_VERT)
    else $error("accumulator write outside the vertical step");
  a_single_write: assert property (@(posedge clk) disable iff (rst)
    !(cur_we && nxt_we))
    else $error("both accumulator stores written for one item");
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV)
    else $error("divider finished outside the divide step");
  a_accept_to_vert: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == S_VERT)
    else $error("accepted item did not reach the vertical step");
`endif

endmodule

// ===== hdl/pbd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the row accumulator stores. No dependencies.
module pbd_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/pbd_div.sv =====
// Restoring divider, one quotient bit per cycle, for the final normalization.
// Depends on pbd_pkg for widths and the request and response types.
module pbd_div (
  input  logic              clk,
  input  logic              rst,
  input  pbd_pkg::div_req_t req,
  output pbd_pkg::div_rsp_t rsp
);

  logic [pbd_pkg::NUM_W-1:0] rem;
  logic [pbd_pkg::NUM_W-1:0] dsh;
  logic [pbd_pkg::QUO_W-1:0] quo;
  logic [pbd_pkg::QCNT_W-1:0] cnt;
  logic busy;
  logic done;
  logic fits;

  assign fits = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.numer;
      dsh <= pbd_pkg::NUM_W'(req.divisor) << (pbd_pkg::QUO_W - 1);
      cnt <= pbd_pkg::QCNT_W'(pbd_pkg::QUO_W - 1);
      quo <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quo <= {quo[pbd_pkg::QUO_W-2:0], fits};
      dsh <= dsh >> 1;
      cnt <= cnt - pbd_pkg::QCNT_W'(1);
    end
  end

  assign rsp.done = done;
  assign rsp.quotient = quo;

endmodule
